>>> hw/rtl/energy_meter_frame_decoder_unit_macros.svh
// Assertion helpers
`ifndef ENERGY_METER_FRAME_DECODER_UNIT_MACROS_SVH
`define ENERGY_METER_FRAME_DECODER_UNIT_MACROS_SVH

`define EMFD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

`define EMFD_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);

`endif

>>> hw/rtl/emfd_pkg.sv
package emfd_pkg;

  localparam int unsigned FrameBytes = 24;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [47:0] voltage_q16;
    logic [23:0] current_value;
    logic [47:0] power_q16;
    logic        power_overflow;
    logic [37:0] energy_e4;
  } out_req_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_PWR_OVF  = 3'd1,
    ST_CAL      = 3'd2,
    ST_CSUM     = 3'd3,
    ST_ZERO_DIV = 3'd4
  } status_e;

  typedef enum logic [0:0] {
    CFG_VOLT = 1'd0,
    CFG_PWR  = 1'd1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_D1, S_M1, S_D2, S_D3, S_M3, S_MDEN, S_DPPK,
    S_MPF, S_DEN, S_FIN, S_OUT
  } state_e;

  localparam logic [7:0]  HdrCal    = 8'haa;
  localparam logic [7:0]  HdrOvfLim = 8'hf0;
  localparam logic [7:0]  HdrOvfFlg = 8'hf1;
  localparam logic [23:0] CoefReset = 24'd197001;
  // 3.6e12 * 65536
  localparam logic [63:0] EnergyNum = 64'd235929600000000000;
  localparam logic [15:0] Ten4      = 16'd10000;

  typedef struct packed {
    logic start;
    logic busy;
  } unit_ctl_t;

endpackage

>>> hw/rtl/energy_meter_frame_decoder_unit.sv
// Decode path: from the last frame byte to out_valid_o a frame runs through
// five serial 64-bit divisions and four multiplies; headers above 0xf0 skip
// one division and one multiply, and rejected frames go straight to output.
// Throughput: one byte per cycle while collecting; frame end blocks input
// until decoding is done and the previous result has been taken.
// Reset: coefficients to 197001, frame waits for a start, counters cleared.
`include "energy_meter_frame_decoder_unit_macros.svh"
module energy_meter_frame_decoder_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  emfd_pkg::in_req_t    in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output emfd_pkg::out_req_t   out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [0:0]           cfg_index_i,
  input  logic [23:0]          cfg_data_i
);
  localparam int unsigned FRAME_BYTES = emfd_pkg::FrameBytes;
  localparam int PW = $clog2(FRAME_BYTES + 1);

  logic [7:0] mem_q [FRAME_BYTES];
  logic [PW-1:0] pos_q;
  logic [7:0] csum_q, povf_q;
  logic lub_q;
  logic [23:0] vcoef_q, pcoef_q;
  emfd_pkg::state_e st_q, st_d;
  logic [63:0] ra_q, rb_q, rc_q;
  emfd_pkg::out_req_t res_q, out_q;
  logic out_v_q;

  logic acc_in, acc_out, last_byte, out_load;
  logic [PW-1:0] wpos;
  logic [7:0] csum_n;

  assign in_ready_o  = (st_q == emfd_pkg::S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign acc_in  = in_valid_i && in_ready_o;
  assign acc_out = out_v_q && out_ready_i;
  assign out_load = (st_q == emfd_pkg::S_OUT) && (!out_v_q || acc_out);
  assign wpos = in_data_i.frame_start ? '0 : pos_q;
  assign last_byte = acc_in && (wpos == PW'(FRAME_BYTES - 1));
  always_comb begin
    csum_n = in_data_i.frame_start ? 8'd0 : csum_q;
    if (wpos >= PW'(2) && wpos <= PW'(FRAME_BYTES - 2))
      csum_n = csum_n + in_data_i.data_byte;
  end

  always_ff @(posedge clk_i) begin
    if (acc_in && wpos < PW'(FRAME_BYTES)) mem_q[wpos[PW-1:0]] <= in_data_i.data_byte;
  end

  // frame fields
  logic [7:0] hdr;
  logic [23:0] vp, vr, cp, cr, pp, pr;
  logic ovf;
  logic [2:0] chk_st;
  assign hdr = mem_q[0];
  assign vp = {mem_q[2], mem_q[3], mem_q[4]};
  assign vr = {mem_q[5], mem_q[6], mem_q[7]};
  assign cp = {mem_q[8], mem_q[9], mem_q[10]};
  assign cr = {mem_q[11], mem_q[12], mem_q[13]};
  assign pp = {mem_q[14], mem_q[15], mem_q[16]};
  assign pr = {mem_q[17], mem_q[18], mem_q[19]};
  assign ovf = hdr > emfd_pkg::HdrOvfLim;
  assign chk_st = (hdr == emfd_pkg::HdrCal) ? emfd_pkg::ST_CAL :
                  (csum_q != mem_q[FRAME_BYTES-1]) ? emfd_pkg::ST_CSUM :
                  emfd_pkg::ST_ZERO_DIV;

  // shared units
  emfd_pkg::unit_ctl_t dctl, mctl;
  logic [63:0] dnum, dden, dquo, ma, mp;
  logic [23:0] mb;
  logic ddone, mdone;

  emfd_div u_div (.clk_i, .rst_ni, .ctl_i(dctl), .num_i(dnum), .den_i(dden),
                  .done_o(ddone), .quo_o(dquo));
  emfd_mul u_mul (.clk_i, .rst_ni, .ctl_i(mctl), .a_i(ma), .b_i(mb),
                  .done_o(mdone), .p_o(mp));

  logic started_q, started_d;
  logic is_div, is_mul;
  always_comb begin
    is_div = (st_q == emfd_pkg::S_D1) || (st_q == emfd_pkg::S_D2) ||
             (st_q == emfd_pkg::S_D3) || (st_q == emfd_pkg::S_DPPK) ||
             (st_q == emfd_pkg::S_DEN);
    is_mul = (st_q == emfd_pkg::S_M1) || (st_q == emfd_pkg::S_M3) ||
             (st_q == emfd_pkg::S_MDEN) || (st_q == emfd_pkg::S_MPF);
  end

  always_comb begin
    dctl.start = is_div && !started_q;
    dctl.busy  = is_div;
    mctl.start = is_mul && !started_q;
    mctl.busy  = is_mul;
    dnum = '0; dden = '0; ma = '0; mb = '0;
    unique case (st_q)
      emfd_pkg::S_D1: begin dnum = {40'd0, vp}; dden = {40'd0, vr}; end
      emfd_pkg::S_D2: begin dnum = {40'd0, cp}; dden = {40'd0, cr}; end
      emfd_pkg::S_D3: begin dnum = {40'd0, pp}; dden = {40'd0, pr}; end
      emfd_pkg::S_DPPK: begin dnum = emfd_pkg::EnergyNum; dden = rc_q; end
      emfd_pkg::S_DEN: begin dnum = ra_q; dden = rb_q; end
      emfd_pkg::S_M1: begin ma = ra_q; mb = vcoef_q; end
      emfd_pkg::S_M3: begin ma = ra_q; mb = pcoef_q; end
      emfd_pkg::S_MDEN: begin ma = {40'd0, pp}; mb = pcoef_q; end
      emfd_pkg::S_MPF: begin ma = {40'd0, povf_q, mem_q[21], mem_q[22]};
                             mb = {8'd0, emfd_pkg::Ten4}; end
      default: ;
    endcase
  end

  logic step_done;
  assign step_done = (is_div && ddone) || (is_mul && mdone);

  always_comb begin
    st_d = st_q;
    started_d = (is_div || is_mul) && !step_done;
    unique case (st_q)
      emfd_pkg::S_IDLE: if (last_byte) st_d = emfd_pkg::S_CHECK;
      emfd_pkg::S_CHECK: begin
        if (hdr == emfd_pkg::HdrCal || csum_q != mem_q[FRAME_BYTES-1]) st_d = emfd_pkg::S_OUT;
        else if (vr == '0 || cr == '0 || (!ovf && pr == '0)) st_d = emfd_pkg::S_OUT;
        else st_d = emfd_pkg::S_MDEN;
      end
      emfd_pkg::S_MDEN: if (step_done) st_d = emfd_pkg::S_D1;
      emfd_pkg::S_D1:   if (step_done) st_d = emfd_pkg::S_M1;
      emfd_pkg::S_M1:   if (step_done) st_d = emfd_pkg::S_D2;
      emfd_pkg::S_D2:   if (step_done) st_d = ovf ? emfd_pkg::S_DPPK : emfd_pkg::S_D3;
      emfd_pkg::S_D3:   if (step_done) st_d = emfd_pkg::S_M3;
      emfd_pkg::S_M3:   if (step_done) st_d = emfd_pkg::S_DPPK;
      emfd_pkg::S_DPPK: if (step_done) st_d = emfd_pkg::S_MPF;
      emfd_pkg::S_MPF:  if (step_done) st_d = emfd_pkg::S_DEN;
      emfd_pkg::S_DEN:  if (step_done) st_d = emfd_pkg::S_FIN;
      emfd_pkg::S_FIN:  st_d = emfd_pkg::S_OUT;
      emfd_pkg::S_OUT:  if (!out_v_q || acc_out) st_d = emfd_pkg::S_IDLE;
      default: st_d = emfd_pkg::S_IDLE;
    endcase
  end

  logic zden;
  assign zden = (rc_q == '0) || (rc_q > emfd_pkg::EnergyNum);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= emfd_pkg::S_IDLE;
      started_q <= 1'b0;
      pos_q <= PW'(FRAME_BYTES);
      csum_q <= '0;
      lub_q <= 1'b0;
      povf_q <= '0;
      vcoef_q <= emfd_pkg::CoefReset;
      pcoef_q <= emfd_pkg::CoefReset;
      out_v_q <= 1'b0;
    end else begin
      st_q <= st_d;
      started_q <= started_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          emfd_pkg::CFG_VOLT: vcoef_q <= cfg_data_i;
          emfd_pkg::CFG_PWR:  pcoef_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (acc_in && (in_data_i.frame_start || pos_q < PW'(FRAME_BYTES))) begin
        pos_q <= wpos + PW'(1);
        csum_q <= csum_n;
      end
      if (st_q == emfd_pkg::S_CHECK && hdr != emfd_pkg::HdrCal &&
          csum_q == mem_q[FRAME_BYTES-1] && mem_q[20][7] != lub_q) begin
        lub_q <= mem_q[20][7];
        povf_q <= povf_q + 8'd1;
      end
      if (out_load) out_v_q <= 1'b1;
      else if (acc_out) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == emfd_pkg::S_CHECK) begin
      res_q <= {chk_st, 159'd0};
    end
    if (is_mul && mdone && st_q == emfd_pkg::S_MDEN) rc_q <= mp;
    if (is_div && ddone) begin
      unique case (st_q)
        emfd_pkg::S_D1, emfd_pkg::S_D3: ra_q <= dquo;
        emfd_pkg::S_D2: res_q.current_value <= dquo[23:0];
        emfd_pkg::S_DPPK: rb_q <= dquo;
        emfd_pkg::S_DEN: res_q.energy_e4 <= dquo[37:0];
        default: ;
      endcase
    end
    if (is_mul && mdone) begin
      unique case (st_q)
        emfd_pkg::S_M1: res_q.voltage_q16 <= mp[47:0];
        emfd_pkg::S_M3: res_q.power_q16 <= mp[47:0];
        emfd_pkg::S_MPF: ra_q <= mp;
        default: ;
      endcase
    end
    if (st_q == emfd_pkg::S_MDEN && !started_q) begin
      res_q.power_q16 <= '0;
    end
    if (st_q == emfd_pkg::S_FIN) begin
      if (zden) begin
        res_q <= {emfd_pkg::ST_ZERO_DIV, 159'd0};
      end else begin
        res_q.status <= (hdr == emfd_pkg::HdrOvfFlg) ? emfd_pkg::ST_PWR_OVF : emfd_pkg::ST_OK;
        res_q.power_overflow <= ovf;
      end
    end
    if (out_load) out_q <= res_q;
  end

  // zero-divisor check on the product happens at FIN, after the ppk division
  // and its use in DEN; a zero product makes DPPK finish with all ones, ignored at FIN.
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  `EMFD_ASSERT_NEXT(a_no_in_busy, clk_i, rst_ni, st_q != emfd_pkg::S_IDLE, !acc_in || st_q == emfd_pkg::S_IDLE, "input accepted while decoding")
  `EMFD_ASSERT(a_pos_range, clk_i, rst_ni, pos_q <= PW'(FRAME_BYTES), "byte position out of range")
  `EMFD_ASSERT_NEXT(a_last_dec, clk_i, rst_ni, last_byte, st_q == emfd_pkg::S_CHECK, "frame end not decoded")
endmodule

>>> hw/rtl/emfd_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module emfd_div (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  emfd_pkg::unit_ctl_t ctl_i,
  input  logic [63:0]   num_i,
  input  logic [63:0]   den_i,
  output logic          done_o,
  output logic [63:0]   quo_o
);
  logic [63:0] rem_q, rem_d, quo_q, quo_d, den_q;
  logic [64:0] trial;
  logic [6:0]  cnt_q, cnt_d;
  logic        run_q, run_d;

  assign trial = {rem_q, quo_q[63]} - {1'b0, den_q};

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    run_d = run_q;
    if (ctl_i.start) begin
      rem_d = '0;
      quo_d = num_i;
      cnt_d = 7'd64;
      run_d = 1'b1;
    end else if (run_q) begin
      if (!trial[64]) begin
        rem_d = trial[63:0];
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = {rem_q[62:0], quo_q[63]};
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) run_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (ctl_i.start) den_q <= den_i;
  end

  assign done_o = ctl_i.busy && !run_q && !ctl_i.start;
  assign quo_o  = quo_q;
endmodule

>>> hw/rtl/emfd_mul.sv
// shift-add multiplier, 8 bits of the narrow operand per cycle
module emfd_mul (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  emfd_pkg::unit_ctl_t ctl_i,
  input  logic [63:0]   a_i,
  input  logic [23:0]   b_i,
  output logic          done_o,
  output logic [63:0]   p_o
);
  logic [63:0] acc_q, a_q;
  logic [23:0] b_q;
  logic [1:0]  cnt_q;
  logic        run_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else if (ctl_i.start) begin
      run_q <= 1'b1;
      cnt_q <= 2'd3;
    end else if (run_q) begin
      cnt_q <= cnt_q - 2'd1;
      if (cnt_q == 2'd1) run_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      acc_q <= '0;
      a_q   <= a_i;
      b_q   <= b_i;
    end else if (run_q) begin
      acc_q <= acc_q + a_q * {56'd0, b_q[7:0]};
      a_q   <= {a_q[55:0], 8'd0};
      b_q   <= {8'd0, b_q[23:8]};
    end
  end

  assign done_o = ctl_i.busy && !run_q && !ctl_i.start;
  assign p_o    = acc_q;
endmodule

>>> tb/sv/energy_meter_frame_decoder_unit_tb.sv
module energy_meter_frame_decoder_unit_tb;
  import emfd_pkg::*;

  localparam int FrameLen = 24;
  localparam int CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_req_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_req_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [0:0] cfg_index_i = '0;
  logic [23:0] cfg_data_i = '0;

  energy_meter_frame_decoder_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // decoder model state
  logic [7:0] frame_mem [FrameLen];
  int unsigned pos_q;
  logic [7:0] sum_q;
  logic toggle_bit_q;
  logic [7:0] wrap_cnt_q;
  logic [23:0] volt_coef_q = CoefReset;
  logic [23:0] pwr_coef_q = CoefReset;

  in_req_t byte_q[$];
  out_req_t decoded_q[$];
  int errors = 0;
  int cycles = 0;
  int frames_seen = 0;
  int status_hits [5];
  int idle_in_pct = 0;
  int idle_out_pct = 0;
  bit sender_pause = 1'b0;
  int hold_reqs = 0;
  int holds_done = 0;
  int hold_cnt = 0;

  function automatic logic [63:0] get24(int at);
    return {40'd0, frame_mem[at], frame_mem[at+1], frame_mem[at+2]};
  endfunction

  function automatic out_req_t decode_frame();
    out_req_t r;
    logic [7:0] hdr;
    logic [63:0] vp, vr, cp, cr, pp, pr, den, ppk, pf;
    logic ovf;
    r = '0;
    hdr = frame_mem[0];
    if (hdr == HdrCal) begin
      r.status = ST_CAL;
      return r;
    end
    if (sum_q != frame_mem[FrameLen-1]) begin
      r.status = ST_CSUM;
      return r;
    end
    if (frame_mem[20][7] != toggle_bit_q) begin
      wrap_cnt_q = wrap_cnt_q + 8'd1;
      toggle_bit_q = frame_mem[20][7];
    end
    vp = get24(2); vr = get24(5);
    cp = get24(8); cr = get24(11);
    pp = get24(14); pr = get24(17);
    ovf = hdr > HdrOvfLim;
    den = pp * {40'd0, pwr_coef_q};
    if (vr == 0 || cr == 0 || (!ovf && pr == 0) || den == 0 || den > EnergyNum) begin
      r.status = ST_ZERO_DIV;
      return r;
    end
    ppk = EnergyNum / den;
    pf = {40'd0, wrap_cnt_q, frame_mem[21], frame_mem[22]};
    r.status = (ovf && hdr == HdrOvfFlg) ? ST_PWR_OVF : ST_OK;
    r.voltage_q16 = 48'((vp / vr) * {40'd0, volt_coef_q});
    r.current_value = 24'(cp / cr);
    r.power_q16 = ovf ? 48'd0 : 48'((pp / pr) * {40'd0, pwr_coef_q});
    r.power_overflow = ovf;
    r.energy_e4 = 38'((pf * 64'd10000) / ppk);
    return r;
  endfunction

  function automatic bit decoder_step(in_req_t it, output out_req_t r);
    r = '0;
    if (it.frame_start) begin
      pos_q = 0;
      sum_q = 8'd0;
    end
    if (pos_q >= FrameLen) return 1'b0;
    frame_mem[pos_q] = it.data_byte;
    if (pos_q >= 2 && pos_q <= FrameLen - 2) sum_q = sum_q + it.data_byte;
    pos_q++;
    if (pos_q < FrameLen) return 1'b0;
    r = decode_frame();
    return 1'b1;
  endfunction

  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h", field, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("energy_meter_frame_decoder_unit test failed");
      $finish;
    end
  end

  // driver
  always @(posedge clk_i) begin
    out_req_t r;
    if (in_valid_i && in_ready_o) begin
      if (decoder_step(byte_q[0], r)) decoded_q.push_back(r);
      void'(byte_q.pop_front());
      if (byte_q.size() > 0 && !sender_pause && $urandom_range(99) >= idle_in_pct) begin
        in_data_i <= byte_q[0];
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end else if (!in_valid_i && rst_ni && byte_q.size() > 0 && !sender_pause &&
                 $urandom_range(99) >= idle_in_pct) begin
      in_data_i <= byte_q[0];
      in_valid_i <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    out_req_t want;
    if (out_valid_o && out_ready_i) begin
      if (decoded_q.size() == 0) begin
        report("unexpected result", {61'd0, out_data_o.status}, 64'd0);
      end else begin
        want = decoded_q.pop_front();
        frames_seen++;
        if (want.status <= ST_ZERO_DIV) status_hits[want.status]++;
        if (out_data_o.status != want.status)
          report("status", out_data_o.status, want.status);
        if (out_data_o.voltage_q16 != want.voltage_q16)
          report("voltage_q16", out_data_o.voltage_q16, want.voltage_q16);
        if (out_data_o.current_value != want.current_value)
          report("current_value", out_data_o.current_value, want.current_value);
        if (out_data_o.power_q16 != want.power_q16)
          report("power_q16", out_data_o.power_q16, want.power_q16);
        if (out_data_o.power_overflow != want.power_overflow)
          report("power_overflow", out_data_o.power_overflow, want.power_overflow);
        if (out_data_o.energy_e4 != want.energy_e4)
          report("energy_e4", out_data_o.energy_e4, want.energy_e4);
      end
    end
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready_i <= 1'b0;
    end else if (hold_reqs != holds_done) begin
      holds_done <= holds_done + 1;
      hold_cnt <= 3000;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= rst_ni && ($urandom_range(99) >= idle_out_pct);
    end
  end

  task automatic cfg_write(cfg_idx_e idx, logic [23:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_VOLT) volt_coef_q = val;
    else pwr_coef_q = val;
  endtask

  function automatic logic [23:0] rand_div();
    int unsigned k;
    k = $urandom_range(11);
    if (k == 0) return 24'd0;
    if (k < 5) return 24'($urandom_range(255, 1));
    return 24'($urandom);
  endfunction

  task automatic push_frame(logic [7:0] b[FrameLen]);
    in_req_t it;
    for (int i = 0; i < FrameLen; i++) begin
      it.data_byte = b[i];
      it.frame_start = (i == 0);
      byte_q.push_back(it);
    end
  endtask

  task automatic add_frame();
    logic [7:0] b[FrameLen];
    logic [7:0] s;
    logic [23:0] v;
    in_req_t it;
    int unsigned k;
    k = $urandom_range(5);
    if (k == 0) begin
      it.frame_start = 1'b1;
      it.data_byte = 8'($urandom);
      byte_q.push_back(it);
      it.frame_start = 1'b0;
      repeat ($urandom_range(22)) begin
        it.data_byte = 8'($urandom);
        byte_q.push_back(it);
      end
    end else if (k == 1) begin
      it.frame_start = 1'b0;
      repeat ($urandom_range(3, 1)) begin
        it.data_byte = 8'($urandom);
        byte_q.push_back(it);
      end
    end
    k = $urandom_range(9);
    case (k)
      0: b[0] = HdrCal;
      1: b[0] = HdrOvfLim;
      2: b[0] = HdrOvfFlg;
      3: b[0] = 8'($urandom_range(255, 242));
      default: b[0] = 8'($urandom_range(239));
    endcase
    b[1] = 8'($urandom);
    for (int f = 0; f < 3; f++) begin
      v = 24'($urandom);
      if ($urandom_range(11) == 0) v = 24'd0;
      {b[2+6*f], b[3+6*f], b[4+6*f]} = v;
      v = rand_div();
      {b[5+6*f], b[6+6*f], b[7+6*f]} = v;
    end
    for (int i = 20; i < 23; i++) b[i] = 8'($urandom);
    s = 8'd0;
    for (int i = 2; i < 23; i++) s = s + b[i];
    b[23] = ($urandom_range(7) == 0) ? s ^ 8'($urandom_range(255, 1)) : s;
    push_frame(b);
  endtask

  task automatic drain();
    wait (byte_q.size() == 0 && !in_valid_i && decoded_q.size() == 0);
    repeat (500) @(posedge clk_i);
  endtask

  initial begin
    logic [7:0] b[FrameLen];
    logic [7:0] s;
    in_req_t it;
    pos_q = FrameLen;
    sum_q = 8'd0;
    toggle_bit_q = 1'b0;
    wrap_cnt_q = 8'd0;
    for (int i = 0; i < FrameLen; i++) frame_mem[i] = 8'd0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    idle_in_pct = 34;
    idle_out_pct = 77;

    // stray byte while waiting for start, then a frame of all-ones fields
    it.data_byte = 8'hff;
    it.frame_start = 1'b0;
    byte_q.push_back(it);
    b[0] = 8'h55;
    for (int i = 1; i < 23; i++) b[i] = 8'hff;
    s = 8'd0;
    for (int i = 2; i < 23; i++) s = s + b[i];
    b[23] = s;
    push_frame(b);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin cfg_write(CFG_VOLT, CoefReset); cfg_write(CFG_PWR, CoefReset); end
        1: begin cfg_write(CFG_VOLT, 24'hffffff); cfg_write(CFG_PWR, 24'hffffff); end
        2: begin cfg_write(CFG_VOLT, 24'd0); cfg_write(CFG_PWR, 24'd0); end
        3: begin cfg_write(CFG_VOLT, 24'd1); cfg_write(CFG_PWR, 24'd1); end
        default: begin
          cfg_write(CFG_VOLT, 24'($urandom));
          cfg_write(CFG_PWR, 24'($urandom));
        end
      endcase
      if (ph == 2) begin
        idle_in_pct = 77;
        idle_out_pct = 34;
      end else if (ph == 4) begin
        idle_in_pct = 0;
        idle_out_pct = 0;
      end
      if (ph == 1) hold_reqs++;
      repeat (4) add_frame();
      if (ph == 3) begin
        // sender waits for all outstanding results
        sender_pause = 1'b1;
        wait (!in_valid_i && decoded_q.size() == 0);
        repeat (50) @(posedge clk_i);
        sender_pause = 1'b0;
      end
      repeat (4) add_frame();
      drain();
    end

    $display("checked %0d frame results: ok %0d, 0xf1 %0d, cal %0d, csum %0d, zero div %0d",
             frames_seen, status_hits[0], status_hits[1], status_hits[2], status_hits[3],
             status_hits[4]);
    $display("coefficients swept over reset, max, zero, one and random values");
    if (errors == 0 && decoded_q.size() == 0) begin
      $display("energy_meter_frame_decoder_unit test passed");
    end else begin
      $display("energy_meter_frame_decoder_unit test failed");
    end
    $finish;
  end

endmodule

>>> energy_meter_frame_decoder_unit.f
+incdir+hw/rtl
hw/rtl/emfd_pkg.sv
hw/rtl/emfd_div.sv
hw/rtl/emfd_mul.sv
hw/rtl/energy_meter_frame_decoder_unit.sv
tb/sv/energy_meter_frame_decoder_unit_tb.sv
